@@ rtl/ebls_pkg.sv @@
// Shared types and constants for the energy budget load shedder.
// Holds the transaction structs, the sequencer state type and the control structs.
// No dependencies.
package ebls_pkg;

  // Size of the consumer slot table.
  localparam int NUM_SLOTS   = 8;
  localparam int SLOT_IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int SLOT_CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam int MASK_SLOTS  = (NUM_SLOTS < 8) ? NUM_SLOTS : 8;

  // Energy datapath widths.
  localparam int ENERGY_W    = 16;
  localparam int SUM_W       = ENERGY_W + SLOT_IDX_W;
  localparam int BAL_W       = SUM_W + 1;
  localparam int LVL_W       = SUM_W + 2;

  // Function codes of an input transaction.
  localparam logic [1:0] FUNC_TICK       = 2'd0;
  localparam logic [1:0] FUNC_CONNECT    = 2'd1;
  localparam logic [1:0] FUNC_DISCONNECT = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_REGEN    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd1;

  typedef struct packed {
    logic [1:0]          func;
    logic [2:0]          slot;
    logic [ENERGY_W-1:0] demand;
  } in_t;

  typedef struct packed {
    logic [ENERGY_W-1:0] stored_level;
    logic [7:0]          online_mask;
    logic                shed;
  } out_t;

  // Sequencer phases.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DECIDE,
    ST_SHED,
    ST_LEVEL,
    ST_FIN
  } state_t;

  // Sequencer to datapath.
  typedef struct packed {
    state_t                phase;
    logic                  rd_en;
    logic [SLOT_IDX_W-1:0] rd_addr;
    logic                  proc_vld;
    logic [SLOT_IDX_W-1:0] proc_idx;
  } ctrl_t;

  // Datapath to sequencer.
  typedef struct packed {
    logic shed_go;
    logic out_free;
  } stat_t;

endpackage

@@ rtl/ebls_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module ebls_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/ebls_ctrl.sv @@
// Sequencer of the energy budget load shedder: phase FSM and slot walk counter.
// Depends on ebls_pkg.
module ebls_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_fire,
  input  logic           in_is_tick,
  input  ebls_pkg::stat_t stat,
  output ebls_pkg::ctrl_t ctrl
);
  import ebls_pkg::*;

  state_t                state;
  state_t                state_next;
  logic [SLOT_CNT_W-1:0] cnt;
  logic                  rd_pend;
  logic [SLOT_IDX_W-1:0] rd_idx;
  logic                  walking;
  logic                  walk_end;

  assign walking  = (state == ST_SUM) || (state == ST_SHED);
  assign walk_end = (cnt == SLOT_CNT_W'(NUM_SLOTS));

  // Next phase.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = in_is_tick ? ST_SUM : ST_FIN;
        end
      end
      ST_SUM: begin
        if (walk_end) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_next = stat.shed_go ? ST_SHED : ST_LEVEL;
      end
      ST_SHED: begin
        if (walk_end) begin
          state_next = ST_LEVEL;
        end
      end
      ST_LEVEL: begin
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Walk counter: one RAM read issued per cycle, data handled the cycle after.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      rd_pend <= 1'b0;
    end else if (walking && !walk_end) begin
      cnt     <= cnt + SLOT_CNT_W'(1);
      rd_pend <= 1'b1;
    end else begin
      cnt     <= '0;
      rd_pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (walking && !walk_end) begin
      rd_idx <= cnt[SLOT_IDX_W-1:0];
    end
  end

  // Control outputs to the datapath.
  always_comb begin
    ctrl.phase    = state;
    ctrl.rd_en    = walking && !walk_end;
    ctrl.rd_addr  = cnt[SLOT_IDX_W-1:0];
    ctrl.proc_vld = walking && rd_pend;
    ctrl.proc_idx = rd_idx;
  end

endmodule

@@ rtl/energy_budget_load_shedder.sv @@
// Energy budget load shedder: an energy store that feeds a table of NUM_SLOTS consumer slots.
// A connect or disconnect transaction updates one slot and goes straight to the result phase,
// which loads the result into the output register. A tick walks the slot demand RAM once to
// sum the connected demands (one read per cycle on the single read port), decides whether
// to shed, and when shedding walks the RAM a second time in ascending slot order to pick
// the consumers that stay online, then updates the stored level and loads its result
// before the next transaction is accepted.
// One transaction is in flight at a time; its result waits in an output register.
// Depends on ebls_pkg, ebls_ram and ebls_ctrl.
module energy_budget_load_shedder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ebls_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ebls_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic [ebls_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ebls_pkg::ENERGY_W-1:0]   cfg_wdata
);
  import ebls_pkg::*;

  ctrl_t                 ctrl;
  stat_t                 stat;
  logic                  in_fire;
  logic                  slot_ok;
  logic [SLOT_IDX_W-1:0] slot_idx;
  logic                  ram_we;
  logic [ENERGY_W-1:0]   rd_data;

  logic [ENERGY_W-1:0]   regen;
  logic [ENERGY_W-1:0]   capacity;
  logic [ENERGY_W-1:0]   stored;
  logic [NUM_SLOTS-1:0]  connected;
  logic [NUM_SLOTS-1:0]  online;
  logic [SUM_W-1:0]      acc;
  logic signed [BAL_W-1:0] bal;
  logic [ENERGY_W-1:0]   rem;
  logic                  failed;
  logic                  shed_r;

  logic [BAL_W-1:0]      deficit;
  logic signed [BAL_W-1:0] bal_src;
  logic signed [LVL_W-1:0] lvl;
  logic [ENERGY_W-1:0]   stored_next;
  logic [7:0]            mask;

  assign in_ready = (ctrl.phase == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign slot_ok  = (32'(in_data.slot) < 32'(NUM_SLOTS));
  assign slot_idx = SLOT_IDX_W'(in_data.slot);
  assign ram_we   = in_fire && (in_data.func == FUNC_CONNECT) && slot_ok;

  // Sequencer.
  ebls_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_fire    (in_fire),
    .in_is_tick (in_data.func == FUNC_TICK),
    .stat       (stat),
    .ctrl       (ctrl)
  );

  // Per-slot demand store.
  ebls_ram #(
    .WIDTH (ENERGY_W),
    .DEPTH (NUM_SLOTS)
  ) u_demand_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_idx),
    .wdata (in_data.demand),
    .re    (ctrl.rd_en),
    .raddr (ctrl.rd_addr),
    .rdata (rd_data)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      regen    <= '0;
      capacity <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_REGEN:    regen    <= cfg_wdata;
        REG_CAPACITY: capacity <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Shedding decision: the demand sum exceeds regeneration and the store cannot cover the deficit.
  always_comb begin
    deficit      = BAL_W'(acc) - BAL_W'(regen);
    stat.shed_go = (acc > SUM_W'(regen)) && (BAL_W'(stored) <= deficit);
    stat.out_free = !out_valid || out_ready;
  end

  // New stored level, clamped to the capacity and to zero.
  always_comb begin
    bal_src = shed_r ? $signed(BAL_W'(rem)) : bal;
    lvl     = $signed(LVL_W'(stored)) + LVL_W'(bal_src);
    if (lvl > $signed(LVL_W'(capacity))) begin
      stored_next = capacity;
    end else if (lvl < 0) begin
      stored_next = '0;
    end else begin
      stored_next = lvl[ENERGY_W-1:0];
    end
  end

  // Slot status bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      connected <= '0;
      online    <= '0;
    end else begin
      if (in_fire && slot_ok && (in_data.func == FUNC_CONNECT)) begin
        connected[slot_idx] <= 1'b1;
        online[slot_idx]    <= 1'b1;
      end else if (in_fire && slot_ok && (in_data.func == FUNC_DISCONNECT)) begin
        connected[slot_idx] <= 1'b0;
        online[slot_idx]    <= 1'b0;
      end
      if ((ctrl.phase == ST_DECIDE) && !stat.shed_go) begin
        online <= online | connected;
      end
      if ((ctrl.phase == ST_SHED) && ctrl.proc_vld && connected[ctrl.proc_idx]) begin
        online[ctrl.proc_idx] <= !failed && (rem > rd_data);
      end
    end
  end

  // Tick arithmetic: demand sum, balance and the shedding walk.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      acc <= '0;
    end else if ((ctrl.phase == ST_SUM) && ctrl.proc_vld && connected[ctrl.proc_idx]) begin
      acc <= acc + SUM_W'(rd_data);
    end
    if (ctrl.phase == ST_DECIDE) begin
      bal    <= $signed(BAL_W'(regen)) - $signed(BAL_W'(acc));
      rem    <= regen;
      failed <= 1'b0;
    end else if ((ctrl.phase == ST_SHED) && ctrl.proc_vld && connected[ctrl.proc_idx]) begin
      if (!failed && (rem > rd_data)) begin
        rem <= rem - rd_data;
      end else begin
        failed <= 1'b1;
      end
    end
  end

  // Shed flag and stored energy.
  always_ff @(posedge clk) begin
    if (rst) begin
      shed_r <= 1'b0;
      stored <= '0;
    end else begin
      if (in_fire) begin
        shed_r <= 1'b0;
      end else if (ctrl.phase == ST_DECIDE) begin
        shed_r <= stat.shed_go;
      end
      if (ctrl.phase == ST_LEVEL) begin
        stored <= stored_next;
      end
    end
  end

  // Online mask of the first eight slots.
  always_comb begin
    mask = '0;
    for (int s = 0; s < MASK_SLOTS; s++) begin
      mask[s] = connected[s] && online[s];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((ctrl.phase == ST_FIN) && stat.out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((ctrl.phase == ST_FIN) && stat.out_free) begin
      out_data.stored_level <= stored;
      out_data.online_mask  <= mask;
      out_data.shed         <= shed_r;
    end
  end

  // A slot is never online without being connected.
  assert property (@(posedge clk) disable iff (rst) (online & ~connected) == '0)
    else $error("online bit set on a disconnected slot");

  // Only one transaction is in flight at a time.
  assert property (@(posedge clk) disable iff (rst) in_fire |=> !in_ready)
    else $error("input accepted while a transaction is in flight");

  // The demand RAM is written only between transactions, never during a walk.
  assert property (@(posedge clk) disable iff (rst) ram_we |-> !ctrl.rd_en && !ctrl.proc_vld)
    else $error("demand RAM written during a slot walk");

  // A result is loaded only when the output register can take it.
  assert property (@(posedge clk) disable iff (rst)
      (out_valid && !out_ready && (ctrl.phase == ST_FIN)) |=> (ctrl.phase == ST_FIN))
    else $error("sequencer left the result phase while the output was blocked");

endmodule

@@ test/energy_budget_load_shedder_tb.sv @@
// Self-checking testbench for the energy budget load shedder.
// Predicts every result transaction and compares it against the block under random idling.
// Depends on ebls_pkg and energy_budget_load_shedder.
module energy_budget_load_shedder_tb;
  import ebls_pkg::*;

  // The function code that the block leaves unused.
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  // Longest busy stretch of one tick, plus margin.
  localparam int SETTLE_CYCLES = 2 * NUM_SLOTS + 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_t in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ENERGY_W-1:0] cfg_wdata;

  // Predictor state: configuration, energy store and slot table.
  logic [ENERGY_W-1:0] regen_cfg;
  logic [ENERGY_W-1:0] cap_cfg;
  logic [ENERGY_W-1:0] level_now;
  logic [ENERGY_W-1:0] slot_draw [NUM_SLOTS];
  bit slot_conn [NUM_SLOTS];
  bit slot_on [NUM_SLOTS];

  // Predicted results waiting for the block to produce them.
  out_t budget_reports[$];

  bit calm;
  int mismatch_count;
  int stray_count;
  int item_count;
  int tick_count;
  int shed_count;
  int result_count;
  int cycle_count;

  energy_budget_load_shedder i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Advance the predicted state by one input transaction and return its result.
  function automatic out_t predict_budget_step(input in_t item);
    out_t res;
    int bal;
    int lvl;
    int s;
    bit shed_now;
    bit broke;
    shed_now = 1'b0;
    broke = 1'b0;
    case (item.func)
      FUNC_TICK: begin
        bal = int'(regen_cfg);
        for (s = 0; s < NUM_SLOTS; s++)
          if (slot_conn[s]) bal -= int'(slot_draw[s]);
        if (bal < 0 && int'(level_now) <= -bal) begin
          // Shedding: keep slots in index order until one does not fit.
          shed_now = 1'b1;
          bal = int'(regen_cfg);
          for (s = 0; s < NUM_SLOTS; s++) begin
            if (slot_conn[s]) begin
              if (!broke && bal > int'(slot_draw[s])) begin
                bal -= int'(slot_draw[s]);
                slot_on[s] = 1'b1;
              end else begin
                broke = 1'b1;
                slot_on[s] = 1'b0;
              end
            end
          end
        end else begin
          for (s = 0; s < NUM_SLOTS; s++)
            if (slot_conn[s]) slot_on[s] = 1'b1;
        end
        lvl = int'(level_now) + bal;
        if (lvl > int'(cap_cfg)) lvl = int'(cap_cfg);
        if (lvl < 0) lvl = 0;
        level_now = lvl[ENERGY_W-1:0];
        tick_count++;
        if (shed_now) shed_count++;
      end
      FUNC_CONNECT: begin
        slot_draw[item.slot] = item.demand;
        slot_conn[item.slot] = 1'b1;
        slot_on[item.slot] = 1'b1;
      end
      FUNC_DISCONNECT: begin
        if (slot_conn[item.slot]) begin
          slot_conn[item.slot] = 1'b0;
          slot_on[item.slot] = 1'b0;
        end
      end
      default: begin
      end
    endcase
    res.stored_level = level_now;
    res.online_mask = '0;
    for (s = 0; s < MASK_SLOTS; s++)
      res.online_mask[s] = slot_conn[s] && slot_on[s];
    res.shed = shed_now;
    return res;
  endfunction

  // Random input transaction; demands are mostly scaled to the regeneration rate.
  function automatic in_t random_item();
    in_t item;
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 7) item.func = FUNC_TICK;
    else if (pick < 14) item.func = FUNC_CONNECT;
    else if (pick < 18) item.func = FUNC_DISCONNECT;
    else item.func = FUNC_SPARE;
    item.slot = 3'($urandom_range(0, 7));
    pick = $urandom_range(0, 9);
    if (pick == 0) item.demand = '0;
    else if (pick == 1) item.demand = '1;
    else if (pick < 4) item.demand = ENERGY_W'($urandom_range(0, 65535));
    else item.demand = ENERGY_W'($urandom_range(0, int'(regen_cfg) / 3 + 2));
    return item;
  endfunction

  function automatic in_t make_item(input logic [1:0] func, input int slot, input int demand);
    in_t item;
    item.func = func;
    item.slot = 3'(slot);
    item.demand = ENERGY_W'(demand);
    return item;
  endfunction

  // Offer one input transaction, sometimes after a random gap, and record its prediction.
  task automatic send_item(input in_t item);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    budget_reports.push_back(predict_budget_step(item));
    item_count++;
  endtask

  // Let every pending result arrive and the block go quiet.
  task automatic drain();
    in_valid <= 1'b0;
    while (budget_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers on consecutive cycles; only called while the block is idle.
  task automatic set_budget(input int regen, input int cap);
    cfg_we <= 1'b1;
    cfg_index <= REG_REGEN;
    cfg_wdata <= ENERGY_W'(regen);
    @(posedge clk);
    regen_cfg = ENERGY_W'(regen);
    cfg_index <= REG_CAPACITY;
    cfg_wdata <= ENERGY_W'(cap);
    @(posedge clk);
    cap_cfg = ENERGY_W'(cap);
    cfg_we <= 1'b0;
  endtask

  // Slot bookkeeping with zero regeneration: extremes, spare code and idle disconnect.
  task automatic test_slot_ops();
    send_item(make_item(FUNC_TICK, 0, 0));
    send_item(make_item(FUNC_CONNECT, 0, 0));
    send_item(make_item(FUNC_CONNECT, 7, 65535));
    send_item(make_item(FUNC_SPARE, 5, 65535));
    send_item(make_item(FUNC_DISCONNECT, 3, 0));
    send_item(make_item(FUNC_CONNECT, 0, 10));
    send_item(make_item(FUNC_TICK, 2, 123));
    send_item(make_item(FUNC_DISCONNECT, 7, 0));
    send_item(make_item(FUNC_DISCONNECT, 0, 0));
    drain();
  endtask

  // A slot that does not fit takes every later slot offline, even ones that would fit.
  task automatic test_shedding();
    set_budget(1000, 3000);
    send_item(make_item(FUNC_CONNECT, 1, 300));
    send_item(make_item(FUNC_CONNECT, 2, 700));
    send_item(make_item(FUNC_CONNECT, 4, 100));
    send_item(make_item(FUNC_TICK, 0, 0));
    send_item(make_item(FUNC_TICK, 0, 0));
    send_item(make_item(FUNC_DISCONNECT, 2, 0));
    send_item(make_item(FUNC_TICK, 0, 0));
    drain();
  endtask

  // Fill the store, then lower the capacity below the stored level.
  task automatic test_capacity_drop();
    set_budget(65535, 65535);
    send_item(make_item(FUNC_DISCONNECT, 1, 0));
    send_item(make_item(FUNC_DISCONNECT, 4, 0));
    send_item(make_item(FUNC_TICK, 0, 0));
    send_item(make_item(FUNC_TICK, 0, 0));
    drain();
    set_budget(0, 100);
    send_item(make_item(FUNC_TICK, 0, 0));
    drain();
  endtask

  // Random traffic across several register settings, extremes included.
  task automatic test_random_budgets();
    int regen_set [7];
    int cap_set [7];
    int p;
    int n;
    regen_set = '{0, 65535, 1200, 300, 65535, 0, 5000};
    cap_set = '{0, 65535, 4000, 65535, 0, 0, 20000};
    regen_set[5] = $urandom_range(0, 65535);
    cap_set[5] = $urandom_range(0, 65535);
    for (p = 0; p < 7; p++) begin
      set_budget(regen_set[p], cap_set[p]);
      for (n = 0; n < 110; n++) send_item(random_item());
      drain();
    end
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_full_rate();
    int n;
    calm = 1'b1;
    set_budget(2000, 8000);
    for (n = 0; n < 150; n++) send_item(random_item());
    drain();
  endtask

  // Stall bursts on the result side.
  initial begin : result_stalls
    int n;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 13);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Compare each result transaction with the oldest prediction.
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      result_count++;
      if (budget_reports.size() == 0) begin
        stray_count++;
        if (mismatch_count + stray_count <= MAX_REPORTS)
          $display("Unexpected result: level %0d mask %b shed %b",
                   out_data.stored_level, out_data.online_mask, out_data.shed);
      end else begin
        want = budget_reports.pop_front();
        if (out_data.stored_level !== want.stored_level ||
            out_data.online_mask !== want.online_mask || out_data.shed !== want.shed) begin
          mismatch_count++;
          if (mismatch_count + stray_count <= MAX_REPORTS)
            $display({"Mismatch on result %0d: expected level %0d mask %b shed %b, ",
                      "got level %0d mask %b shed %b"},
                     result_count, want.stored_level, want.online_mask, want.shed,
                     out_data.stored_level, out_data.online_mask, out_data.shed);
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, budget_reports.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    rst <= 1'b1;
    calm = 1'b0;
    regen_cfg = '0;
    cap_cfg = '0;
    level_now = '0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      slot_draw[s] = '0;
      slot_conn[s] = 1'b0;
      slot_on[s] = 1'b0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);

    test_slot_ops();
    test_shedding();
    test_capacity_drop();
    test_random_budgets();
    test_full_rate();

    if (budget_reports.size() != 0) mismatch_count += budget_reports.size();
    $display("Sent %0d transactions (%0d ticks, %0d of them shedding) and checked %0d results.",
             item_count, tick_count, shed_count, result_count);
    $display("Mismatches: %0d, unexpected results: %0d.", mismatch_count, stray_count);
    if (mismatch_count == 0 && stray_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ebls_pkg.sv
rtl/ebls_ram.sv
rtl/ebls_ctrl.sv
rtl/energy_budget_load_shedder.sv
test/energy_budget_load_shedder_tb.sv
